// ----- rtl/core/pcf_pkg.sv -----
// ----------------------------------------------------------------------------
// pcf_pkg: shared definitions for the partitioned convolution filter
// Sizes, fixed-point constants, request codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int MAX_TAPS = 4096;
    localparam int ADDR_W   = $clog2(MAX_TAPS);
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int DATA_W   = 24;
    localparam int FRAC_W   = 23;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int RES_W    = ACC_W - FRAC_W;
    localparam int Q_MAX    = 8388607;
    localparam int Q_MIN    = -8388608;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic              start;
        logic              load;
        logic              clear;
        logic              issue;
        logic [ADDR_W-1:0] tap_idx;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/core/partitioned_convolution_filter.sv -----
// ----------------------------------------------------------------------------
// partitioned_convolution_filter: long FIR convolution engine
// Input beats carry a Q1.23 sample, a coefficient load or a history clear.
// Each sample beat yields one output beat: the sum of coeff[k] * x[n-k] over
// k below tap_count, rounded to nearest and saturated to 24 bits.
// Load and clear beats give no output and do not raise the stall. A sample
// beat holds the input stall high after acceptance through the run over
// tap_count taps (no run when tap_count is zero) and the drain, which waits
// for an empty pipeline and a free output register; its result becomes
// valid at the same edge at which the stall falls. The single MAC unit reads
// one coefficient and one history word per cycle, then two pipeline stages.
// The user must write tap_count through the configuration channel only while
// idle; the block does not enforce this. Values above 4096 act as 4096. Reset
// clears the tap count, history pointer and fill count; the history reads as
// zeros, no clearing pass is needed. Coefficients must be loaded before use.
// A stalled output beat holds in the output register; the next input beat is
// still accepted, and its result waits for the register to be freed.
// ----------------------------------------------------------------------------
module partitioned_convolution_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_req_type,
    input  logic [pcf_pkg::ADDR_W-1:0]        i_coef_index,
    input  logic signed [pcf_pkg::DATA_W-1:0] i_in_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [pcf_pkg::DATA_W-1:0] o_out_sample,
    output logic                              o_saturated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pcf_pkg::CNT_W-1:0]         i_cfg_tap_count
);

    // Command and status bundles between the sequencer and the datapath.
    pcf_pkg::t_cmd    w_cmd;
    pcf_pkg::t_status w_status;

    // The sequencer owns the tap count and the tap index.
    pcf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_req_type      (i_req_type),
        .o_in_stall      (o_in_stall),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_tap_count (i_cfg_tap_count),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    // The datapath holds both memories, the MAC pipeline and the result.
    pcf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_coef_index (i_coef_index),
        .i_in_value   (i_in_value),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_sample (o_out_sample),
        .o_saturated  (o_saturated)
    );

    // When the block takes input beats, no product is still in flight.
    a_idle_pipe_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_status.busy)
        else $error("MAC pipeline busy while idle");

    // An accepted sample beat always starts a pass.
    a_sample_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_req_type == pcf_pkg::REQ_SAMPLE))
        |=> o_in_stall)
        else $error("sample beat did not start a pass");

    // A load beat does not stall the input.
    a_load_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_req_type == pcf_pkg::REQ_LOAD))
        |=> !o_in_stall)
        else $error("load beat held the input");

    // A saturated result sits at one end of the Q1.23 range.
    a_sat_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
        ((o_out_sample == pcf_pkg::DATA_W'(pcf_pkg::Q_MAX)) ||
         (o_out_sample == pcf_pkg::DATA_W'(pcf_pkg::Q_MIN))))
        else $error("saturation flag with unclipped value");

endmodule

// ----- rtl/core/pcf_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcf_ctrl: request sequencer
// Decodes input beats, holds the tap count register and steps the tap index
// through the multiply-accumulate pass of each sample.
// ----------------------------------------------------------------------------
module pcf_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [1:0]               i_req_type,
    output logic                     o_in_stall,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [pcf_pkg::CNT_W-1:0] i_cfg_tap_count,
    input  pcf_pkg::t_status         i_status,
    output pcf_pkg::t_cmd            o_cmd
);

    pcf_pkg::t_state             r_state, n_state;
    logic [pcf_pkg::CNT_W-1:0]   r_k, n_k;
    logic [pcf_pkg::CNT_W-1:0]   r_taps, n_taps;
    logic [pcf_pkg::CNT_W-1:0]   r_tap_count;
    logic [pcf_pkg::CNT_W-1:0]   w_taps_clamped;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != pcf_pkg::ST_IDLE);

    assign w_taps_clamped = (r_tap_count > pcf_pkg::CNT_W'(pcf_pkg::MAX_TAPS))
                          ? pcf_pkg::CNT_W'(pcf_pkg::MAX_TAPS) : r_tap_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcf_pkg::ST_IDLE;
            r_k         <= '0;
            r_taps      <= '0;
            r_tap_count <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_taps  <= n_taps;
            if (i_cfg_valid) begin
                r_tap_count <= i_cfg_tap_count;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_taps  = r_taps;
        o_cmd   = '0;
        o_cmd.tap_idx = r_k[pcf_pkg::ADDR_W-1:0];
        case (r_state)
            pcf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (pcf_pkg::t_req'(i_req_type))
                        pcf_pkg::REQ_SAMPLE: begin
                            o_cmd.start = 1'b1;
                            n_k    = '0;
                            n_taps = w_taps_clamped;
                            n_state = (w_taps_clamped == '0) ? pcf_pkg::ST_DRAIN
                                                             : pcf_pkg::ST_RUN;
                        end
                        pcf_pkg::REQ_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        pcf_pkg::REQ_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pcf_pkg::ST_RUN: begin
                o_cmd.issue = 1'b1;
                n_k = r_k + 1'b1;
                if (n_k == r_taps) begin
                    n_state = pcf_pkg::ST_DRAIN;
                end
            end
            pcf_pkg::ST_DRAIN: begin
                if (!i_status.busy && i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = pcf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/pcf_datapath.sv -----
// ----------------------------------------------------------------------------
// pcf_datapath: storage and multiply-accumulate unit
// Coefficient and sample history memories, the MAC pipeline, rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
module pcf_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pcf_pkg::t_cmd                    i_cmd,
    input  logic [pcf_pkg::ADDR_W-1:0]       i_coef_index,
    input  logic signed [pcf_pkg::DATA_W-1:0] i_in_value,
    output pcf_pkg::t_status                 o_status,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [pcf_pkg::DATA_W-1:0] o_out_sample,
    output logic                             o_saturated
);

    logic signed [pcf_pkg::DATA_W-1:0] r_coef_mem [pcf_pkg::MAX_TAPS];
    logic signed [pcf_pkg::DATA_W-1:0] r_hist_mem [pcf_pkg::MAX_TAPS];

    logic [pcf_pkg::ADDR_W-1:0]        r_ptr;
    logic [pcf_pkg::ADDR_W-1:0]        r_cur_ptr;
    logic [pcf_pkg::CNT_W-1:0]         r_fill;

    logic                              r_rd_v;
    logic                              r_rd_live;
    logic signed [pcf_pkg::DATA_W-1:0] r_coef_rd;
    logic signed [pcf_pkg::DATA_W-1:0] r_hist_rd;
    logic signed [pcf_pkg::DATA_W-1:0] w_hist_live;

    logic                              r_prod_v;
    logic signed [pcf_pkg::PROD_W-1:0] r_prod;
    logic signed [pcf_pkg::ACC_W-1:0]  r_acc;

    logic signed [pcf_pkg::ACC_W-1:0]  w_rnd;
    logic signed [pcf_pkg::RES_W-1:0]  w_q;
    logic                              w_hi;
    logic                              w_lo;

    logic                              r_out_valid;
    logic signed [pcf_pkg::DATA_W-1:0] r_out_sample;
    logic                              r_saturated;

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_coef_mem[i_coef_index] <= i_in_value;
        end
        if (i_cmd.issue) begin
            r_coef_rd <= r_coef_mem[i_cmd.tap_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hist_mem[r_ptr] <= i_in_value;
        end
        if (i_cmd.issue) begin
            r_hist_rd <= r_hist_mem[r_cur_ptr - i_cmd.tap_idx];
        end
    end

    // The fill count stands in for clearing: a history slot older than the
    // number of samples since the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_fill   <= '0;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.issue;
            r_prod_v <= r_rd_v;
            if (i_cmd.clear) begin
                r_ptr  <= '0;
                r_fill <= '0;
            end else if (i_cmd.start) begin
                r_ptr <= r_ptr + 1'b1;
                if (r_fill != pcf_pkg::CNT_W'(pcf_pkg::MAX_TAPS)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cur_ptr <= r_ptr;
        end
        if (i_cmd.issue) begin
            r_rd_live <= ({1'b0, i_cmd.tap_idx} < r_fill);
        end
    end

    assign w_hist_live = r_rd_live ? r_hist_rd : '0;

    always_ff @(posedge i_clk) begin
        r_prod <= r_coef_rd * w_hist_live;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + pcf_pkg::ACC_W'(r_prod);
        end
    end

    // Round to nearest with ties upwards, then clip to the Q1.23 range.
    assign w_rnd = r_acc + (pcf_pkg::ACC_W'(1) <<< (pcf_pkg::FRAC_W - 1));
    assign w_q   = w_rnd[pcf_pkg::ACC_W-1:pcf_pkg::FRAC_W];
    assign w_hi  = (w_q > pcf_pkg::RES_W'(pcf_pkg::Q_MAX));
    assign w_lo  = (w_q < pcf_pkg::RES_W'(pcf_pkg::Q_MIN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (w_hi) begin
                r_out_sample <= pcf_pkg::DATA_W'(pcf_pkg::Q_MAX);
            end else if (w_lo) begin
                r_out_sample <= pcf_pkg::DATA_W'(pcf_pkg::Q_MIN);
            end else begin
                r_out_sample <= w_q[pcf_pkg::DATA_W-1:0];
            end
            r_saturated <= w_hi | w_lo;
        end
    end

    assign o_status.busy     = r_rd_v | r_prod_v;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_sample      = r_out_sample;
    assign o_saturated       = r_saturated;

endmodule
